@@ rtl/thts_pkg.sv @@
// shared types and constants for the tunnel handshake timer scheduler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package thts_pkg;

    // event kinds carried on s_tuser
    localparam logic [2:0] EV_TICK    = 3'd0;
    localparam logic [2:0] EV_TX      = 3'd1;
    localparam logic [2:0] EV_REQ     = 3'd2;
    localparam logic [2:0] EV_ACC     = 3'd3;
    localparam logic [2:0] EV_FAIL    = 3'd4;
    localparam logic [2:0] EV_RESTART = 3'd5;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_HS_TIMEOUT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REKEY_INT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INT    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE_INT = 8'd3;

    // reset values of the interval registers, in microseconds
    localparam logic [31:0] RST_HS_TIMEOUT    = 32'd5000000;
    localparam logic [31:0] RST_REKEY_INT     = 32'd120000000;
    localparam logic [31:0] RST_RETRY_INT     = 32'd5000000;
    localparam logic [31:0] RST_KEEPALIVE_INT = 32'd10000000;

    typedef struct packed {
        logic [31:0] handshake_timeout;
        logic [31:0] rekey_interval;
        logic [31:0] retry_interval;
        logic [31:0] keepalive_interval;
    } cfg_regs_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] now_time;
        logic        send_ok;
    } event_t;

    typedef struct packed {
        logic send_keepalive;
        logic start_handshake;
    } result_t;

endpackage

@@ rtl/tunnel_handshake_timer_scheduler_unit.sv @@
// top level of the tunnel handshake and keepalive timer scheduler
// depends on thts_pkg, thts_cfg and thts_core
`timescale 1ns / 1ps

// Usage:
// Events enter on the s_ stream: s_tuser carries the event kind (tick, transmit,
// handshake request, accept, failure, restart), s_tdata the 64-bit microsecond
// timestamp and the send_ok flag. Every event yields exactly one result beat on
// the m_ stream: bit 0 asks for a handshake, bit 1 for a keepalive; both are
// zero for anything but a tick. Interval registers are written over the cfg
// channel (index 0..3); the user must write them only while no event is in
// flight; the block itself does not enforce this. An accepted beat sits in the
// input register, is evaluated against the timer state and is captured into
// the result register, which drives m_tvalid, once the stage advances.
// Throughput: one event per cycle while the result stream is not stalled; the
// state update compares 64-bit wrapping differences combinationally, so
// consecutive events chain directly. When m_tready is low the result register
// holds, the input register still takes one more beat, and s_tready drops only
// once both are full. Reset clears the timer state, all flags and the valid
// bits of both pipeline registers and loads the default intervals.

module tunnel_handshake_timer_scheduler_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // event stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [71:0]                    s_tdata,   // [63:0] now_time, [64] send_ok
    input  logic [2:0]                     s_tuser,   // [2:0] func
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [0] start_handshake, [1] send_keepalive
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [thts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import thts_pkg::*;

    cfg_regs_t cfg;
    event_t    stage_reg;
    logic      stage_valid_reg;
    result_t   res;
    result_t   out_reg;
    logic      out_valid_reg;
    logic      advance;
    logic      fire;

    thts_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // the stage moves on whenever the result register is free or draining
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = stage_valid_reg && advance;
    assign s_tready = !stage_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            stage_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            stage_reg.func     <= s_tuser;
            stage_reg.now_time <= s_tdata[63:0];
            stage_reg.send_ok  <= s_tdata[64];
        end
    end

    thts_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .ev    (stage_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.send_keepalive, out_reg.start_handshake};

    // every evaluated event lands in the result register
    a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("evaluated event did not reach the result register");

    // only ticks may raise a request
    a_non_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && stage_reg.func != EV_TICK) |=> (m_tdata[1:0] == 2'b00))
        else $error("non-tick event produced a request");

    // an empty result register never backs up the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result register empty");

endmodule

@@ rtl/thts_cfg.sv @@
// interval configuration registers written over the config channel
// depends on thts_pkg
`timescale 1ns / 1ps

module thts_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [thts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output thts_pkg::cfg_regs_t           cfg
);
    import thts_pkg::*;

    cfg_regs_t cfg_reg;

    // writes are always accepted and land in the register file
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register file, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.handshake_timeout  <= RST_HS_TIMEOUT;
            cfg_reg.rekey_interval     <= RST_REKEY_INT;
            cfg_reg.retry_interval     <= RST_RETRY_INT;
            cfg_reg.keepalive_interval <= RST_KEEPALIVE_INT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HS_TIMEOUT:    cfg_reg.handshake_timeout  <= cfg_data;
                CFG_REKEY_INT:     cfg_reg.rekey_interval     <= cfg_data;
                CFG_RETRY_INT:     cfg_reg.retry_interval     <= cfg_data;
                CFG_KEEPALIVE_INT: cfg_reg.keepalive_interval <= cfg_data;
                default:           ;
            endcase
        end
    end

endmodule

@@ rtl/thts_core.sv @@
// timer state registers and the per-event next-state and decision logic
// depends on thts_pkg
`timescale 1ns / 1ps

module thts_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  thts_pkg::event_t    ev,
    input  thts_pkg::cfg_regs_t cfg,
    output thts_pkg::result_t   res
);
    import thts_pkg::*;

    logic [63:0] seen_reg, seen_next;
    logic [63:0] send_reg, send_next;
    logic [63:0] acc_t_reg, acc_t_next;
    logic [63:0] pend_t_reg, pend_t_next;
    logic [63:0] rty_t_reg, rty_t_next;
    logic        acc_f_reg, acc_f_next;
    logic        pend_f_reg, pend_f_next;
    logic        rty_f_reg, rty_f_next;

    logic        back;
    logic [63:0] now;
    logic [63:0] send_rb, acc_t_rb, pend_t_rb, rty_t_rb;
    logic        timed_out, rekey_elapsed, retry_elapsed, ka_due;
    logic        pend_f_tk, rty_f_tk;
    logic [63:0] rty_t_tk;

    assign now = ev.now_time;

    // rebase start times when time steps backwards
    assign back      = now < seen_reg;
    assign send_rb   = back ? now : send_reg;
    assign acc_t_rb  = (back && acc_f_reg)  ? now : acc_t_reg;
    assign pend_t_rb = (back && pend_f_reg) ? now : pend_t_reg;
    assign rty_t_rb  = (back && rty_f_reg)  ? now : rty_t_reg;

    // tick decisions, all on wrapping 64-bit differences
    assign timed_out = pend_f_reg &&
                       ((now - pend_t_rb) >= {32'd0, cfg.handshake_timeout});
    assign pend_f_tk = pend_f_reg && !timed_out;
    assign rty_f_tk  = rty_f_reg || timed_out;
    assign rty_t_tk  = timed_out ? now : rty_t_rb;
    assign rekey_elapsed = acc_f_reg && !rty_f_tk &&
                           ((now - acc_t_rb) >= {32'd0, cfg.rekey_interval});
    assign retry_elapsed = rty_f_tk &&
                           ((now - rty_t_tk) >= {32'd0, cfg.retry_interval});
    assign ka_due    = ev.send_ok &&
                       ((now - send_rb) >= {32'd0, cfg.keepalive_interval});

    // next state and result for the event
    always_comb
    begin
        seen_next   = seen_reg;
        send_next   = send_reg;
        acc_t_next  = acc_t_reg;
        pend_t_next = pend_t_reg;
        rty_t_next  = rty_t_reg;
        acc_f_next  = acc_f_reg;
        pend_f_next = pend_f_reg;
        rty_f_next  = rty_f_reg;
        res         = '0;
        if (ev.func <= EV_FAIL)
        begin
            seen_next   = now;
            send_next   = send_rb;
            acc_t_next  = acc_t_rb;
            pend_t_next = pend_t_rb;
            rty_t_next  = rty_t_rb;
        end
        case (ev.func)
            EV_RESTART:
            begin
                seen_next   = now;
                send_next   = now;
                acc_t_next  = '0;
                pend_t_next = '0;
                rty_t_next  = '0;
                acc_f_next  = 1'b0;
                pend_f_next = 1'b0;
                rty_f_next  = 1'b0;
            end
            EV_TX:
            begin
                send_next = now;
            end
            EV_REQ:
            begin
                pend_f_next = 1'b1;
                pend_t_next = now;
                rty_f_next  = 1'b0;
            end
            EV_ACC:
            begin
                acc_f_next  = 1'b1;
                acc_t_next  = now;
                pend_f_next = 1'b0;
                rty_f_next  = 1'b0;
            end
            EV_FAIL:
            begin
                pend_f_next = 1'b0;
                rty_f_next  = 1'b1;
                rty_t_next  = now;
            end
            EV_TICK:
            begin
                pend_f_next = pend_f_tk;
                rty_f_next  = rty_f_tk;
                rty_t_next  = rty_t_tk;
                if (!pend_f_tk && (rekey_elapsed || retry_elapsed))
                begin
                    res.start_handshake = 1'b1;
                    pend_f_next         = 1'b1;
                    pend_t_next         = now;
                    rty_f_next          = 1'b0;
                end
                if (ka_due)
                begin
                    res.send_keepalive = 1'b1;
                    send_next          = now;
                end
            end
            default:
            begin
            end
        endcase
    end

    // state registers advance once per event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= '0;
            send_reg   <= '0;
            acc_t_reg  <= '0;
            pend_t_reg <= '0;
            rty_t_reg  <= '0;
            acc_f_reg  <= 1'b0;
            pend_f_reg <= 1'b0;
            rty_f_reg  <= 1'b0;
        end
        else if (fire)
        begin
            seen_reg   <= seen_next;
            send_reg   <= send_next;
            acc_t_reg  <= acc_t_next;
            pend_t_reg <= pend_t_next;
            rty_t_reg  <= rty_t_next;
            acc_f_reg  <= acc_f_next;
            pend_f_reg <= pend_f_next;
            rty_f_reg  <= rty_f_next;
        end
    end

endmodule
